FILE: hw/rtl/angle_kalman_filter_unit_macros.svh
// Assertion macros shared by the angle Kalman filter RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ANGLE_KALMAN_FILTER_UNIT_MACROS_SVH
`define ANGLE_KALMAN_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define AKF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed in angle Kalman filter");
// Next-cycle implication, disabled during reset.
`define AKF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed in angle Kalman filter");
`else
`define AKF_ASSERT_NOW(label, clk, rstn, ante, cons)
`define AKF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/akf_pkg.sv
// Package for the angle Kalman filter: widths, register codes, sequencer states
// and saturation helpers. No dependencies.
`timescale 1ns / 1ps
package akf_pkg;
    localparam int COV_FRAC_BITS_DEF = 24;
    localparam int DT_FRAC_BITS = 16;
    localparam int WORD_W = 32;
    localparam int REG_W = 31;
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 33;
    localparam int MUL_RES_W = 53;
    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_QA = 2'd0;
    localparam logic [1:0] REG_QB = 2'd1;
    localparam logic [1:0] REG_R = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ANGLE,
        ST_MUL_T,
        ST_MUL_INNER,
        ST_MUL_QB,
        ST_DIV_K0,
        ST_DIV_K1,
        ST_MUL_KY0,
        ST_MUL_KY1,
        ST_MUL_KP10,
        ST_MUL_KP00,
        ST_MUL_KP11,
        ST_MUL_KP01,
        ST_OUT
    } akf_state_t;

    typedef struct packed {
        logic start;
        logic dt_op;
    } mul_ctrl_t;

    function automatic logic signed [63:0] ext64(input logic signed [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction
endpackage

FILE: hw/rtl/akf_serial_mul.sv
// Bit-serial signed multiplier with rounding shift for the angle Kalman filter.
// Depends on akf_pkg.
`timescale 1ns / 1ps
module akf_serial_mul #(
    parameter int COV_FRAC_BITS = akf_pkg::COV_FRAC_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  akf_pkg::mul_ctrl_t                          ctrl,
    input  logic signed [akf_pkg::MUL_A_W-1:0]          op_a,
    input  logic signed [akf_pkg::MUL_B_W-1:0]          op_b,
    output logic                                        done,
    output logic signed [akf_pkg::MUL_RES_W-1:0]        result
);
    localparam int CNT_W = $clog2(akf_pkg::WORD_W);
    localparam int HI_W = akf_pkg::MUL_A_W + 1;
    localparam int FULL_W = HI_W + akf_pkg::MUL_B_W + 1;
    localparam int SH_DT = 2 * akf_pkg::DT_FRAC_BITS;
    localparam int SH_K = COV_FRAC_BITS + 1;
    localparam logic signed [FULL_W-1:0] RND_DT = FULL_W'(1) << (SH_DT - 1);
    localparam logic signed [FULL_W-1:0] RND_K = FULL_W'(1) << (SH_K - 1);

    logic                               busy_reg, busy_next;
    logic                               fin_reg, fin_next;
    logic                               done_reg, done_next;
    logic                               dt_reg, dt_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic signed [akf_pkg::MUL_A_W-1:0] a_reg, a_next;
    logic [akf_pkg::MUL_B_W-1:0]        b_reg, b_next;
    logic signed [HI_W-1:0]             hi_reg, hi_next;
    logic [akf_pkg::MUL_B_W-1:0]        lo_reg, lo_next;
    logic signed [akf_pkg::MUL_RES_W-1:0] res_reg, res_next;

    logic                   last;
    logic signed [HI_W-1:0] a_ext, addend, sum;
    logic signed [FULL_W-1:0] full, rounded, shifted;

    always_comb begin
        last = (cnt_reg == (dt_reg ? CNT_W'(akf_pkg::DT_FRAC_BITS)
                                   : CNT_W'(akf_pkg::WORD_W - 1)));
        a_ext = {a_reg[akf_pkg::MUL_A_W-1], a_reg};
        if (b_reg[0]) begin
            addend = last ? -a_ext : a_ext;
        end else begin
            addend = '0;
        end
        sum = hi_reg + addend;
        full = {hi_reg[HI_W-1], hi_reg, lo_reg};
        rounded = full + (dt_reg ? RND_DT : RND_K);
        shifted = dt_reg ? (rounded >>> SH_DT) : (rounded >>> SH_K);
    end

    always_comb begin
        busy_next = busy_reg;
        fin_next = 1'b0;
        done_next = 1'b0;
        dt_next = dt_reg;
        cnt_next = cnt_reg;
        a_next = a_reg;
        b_next = b_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        res_next = res_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            dt_next = ctrl.dt_op;
            cnt_next = '0;
            a_next = op_a;
            b_next = op_b;
            hi_next = '0;
            lo_next = '0;
        end else if (busy_reg) begin
            hi_next = {sum[HI_W-1], sum[HI_W-1:1]};
            lo_next = {sum[0], lo_reg[akf_pkg::MUL_B_W-1:1]};
            b_next = {1'b0, b_reg[akf_pkg::MUL_B_W-1:1]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last) begin
                busy_next = 1'b0;
                fin_next = 1'b1;
            end
        end else if (fin_reg) begin
            res_next = shifted[akf_pkg::MUL_RES_W-1:0];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg <= fin_next;
            done_reg <= done_next;
        end
        dt_reg <= dt_next;
        cnt_reg <= cnt_next;
        a_reg <= a_next;
        b_reg <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign result = res_reg;
endmodule

FILE: hw/rtl/akf_serial_div.sv
// Restoring bit-serial divider for the Kalman gains, with signed saturation.
// Depends on akf_pkg.
`timescale 1ns / 1ps
module akf_serial_div #(
    parameter int COV_FRAC_BITS = akf_pkg::COV_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [akf_pkg::WORD_W-1:0]  num,
    input  logic [akf_pkg::WORD_W:0]           den,
    output logic                               done,
    output logic signed [akf_pkg::WORD_W-1:0]  quot
);
    localparam int W = akf_pkg::WORD_W + COV_FRAC_BITS;
    localparam int CNT_W = $clog2(W);
    localparam int REM_W = akf_pkg::WORD_W + 2;
    localparam logic [W-1:0] POS_MAX = W'(32'h7FFFFFFF);
    localparam logic [W-1:0] NEG_LIM = W'(32'h80000000);

    logic                 busy_reg, busy_next;
    logic                 fin_reg, fin_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [W-1:0]         dq_reg, dq_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [akf_pkg::WORD_W:0] den_reg, den_next;
    logic signed [akf_pkg::WORD_W-1:0] q_reg, q_next;

    logic [akf_pkg::WORD_W-1:0] mag;
    logic [REM_W-1:0]           trial;
    logic                       ge;
    logic [akf_pkg::WORD_W-1:0] q_low;

    always_comb begin
        mag = num[akf_pkg::WORD_W-1] ? (~num + 32'd1) : num;
        trial = {rem_reg[REM_W-2:0], dq_reg[W-1]};
        ge = (trial >= {1'b0, den_reg});
        q_low = dq_reg[akf_pkg::WORD_W-1:0];
    end

    always_comb begin
        busy_next = busy_reg;
        fin_next = 1'b0;
        done_next = 1'b0;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        dq_next = dq_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        q_next = q_reg;
        if (start) begin
            busy_next = 1'b1;
            neg_next = num[akf_pkg::WORD_W-1];
            cnt_next = '0;
            dq_next = {mag, {COV_FRAC_BITS{1'b0}}};
            rem_next = '0;
            den_next = den;
        end else if (busy_reg) begin
            rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
            dq_next = {dq_reg[W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                fin_next = 1'b1;
            end
        end else if (fin_reg) begin
            done_next = 1'b1;
            if (neg_reg) begin
                q_next = (dq_reg > NEG_LIM) ? 32'sh80000000 : (~q_low + 32'd1);
            end else begin
                q_next = (dq_reg > POS_MAX) ? 32'sh7FFFFFFF : q_low;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg <= fin_next;
            done_reg <= done_next;
        end
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        dq_reg <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

FILE: hw/rtl/angle_kalman_filter_unit.sv
// Top level of the two-state angle Kalman filter: stream ports, APB registers,
// sequencer and filter state. Depends on akf_pkg, akf_serial_mul, akf_serial_div.
`timescale 1ns / 1ps
`include "angle_kalman_filter_unit_macros.svh"
// The block fuses a measured angle with a gyro rate and returns one word per input
// word: the filtered angle and the bias-corrected rate, both signed Q16.16 and
// saturated. Set tuser to 1 to load the angle estimate straight from the measured
// angle; the result then follows in the cycle after acceptance. A filter update runs
// predict and correct on one bit-serial multiplier and one restoring divider, one bit
// per cycle: four multiplies by the time step take 17 steps each, six gain multiplies
// take 32 steps each, and the two gain divisions take 32 + COV_FRAC_BITS steps each,
// with a hand-over between sequencer and unit around every operation. The default
// COV_FRAC_BITS is 24; the gains stay zero and the divisions are skipped when
// P00 plus the measurement noise is not positive. One word is worked on at a time:
// the input is ready only while the block is idle, and the result word is held on the
// master side until it is taken. The noise registers are written through the APB port
// at byte addresses 0, 4 and 8 and should only be changed while the block is idle.
module angle_kalman_filter_unit #(
    parameter int COV_FRAC_BITS = akf_pkg::COV_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [79:0]                     s_tdata,  // measured_angle, measured_rate, time_step
    input  logic [0:0]                      s_tuser,  // mode
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,  // angle_estimate, rate_estimate
    // Register port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [akf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    localparam logic [akf_pkg::REG_W-1:0] QA_RST =
        akf_pkg::REG_W'((((64'd1 << COV_FRAC_BITS) + 64'd500) / 64'd1000));
    localparam logic [akf_pkg::REG_W-1:0] QB_RST =
        akf_pkg::REG_W'((((64'd3 << COV_FRAC_BITS) + 64'd500) / 64'd1000));
    localparam logic [akf_pkg::REG_W-1:0] R_RST =
        akf_pkg::REG_W'((((64'd3 << COV_FRAC_BITS) + 64'd50) / 64'd100));

    akf_pkg::akf_state_t state_reg, state_next;
    logic launch_reg, launch_next;

    logic [akf_pkg::REG_W-1:0] qa_reg, qb_reg, r_reg;

    logic signed [31:0] angle_reg, bias_reg, rate_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] ma_reg, y_reg, k0_reg, k1_reg;
    logic [15:0]        dt_reg;
    logic signed [akf_pkg::MUL_A_W-1:0] inner_reg;

    logic                 s_accept;
    logic                 cfg_write;
    akf_pkg::mul_ctrl_t   mul_ctrl;
    logic signed [akf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [akf_pkg::MUL_B_W-1:0] mul_b;
    logic                 mul_done;
    logic signed [akf_pkg::MUL_RES_W-1:0] mul_res;
    logic signed [63:0]   mul_res64;
    logic                 div_start;
    logic signed [31:0]   div_num;
    logic                 div_done;
    logic signed [31:0]   div_quot;
    logic signed [33:0]   innov_den;
    logic                 gain_pos;
    logic signed [akf_pkg::MUL_A_W-1:0] inner_calc;
    logic signed [akf_pkg::MUL_B_W-1:0] dt_b;

    assign s_accept = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Denominator of both gains, taken after the covariance predict.
    assign innov_den = {{2{p00_reg[31]}}, p00_reg} + {3'b000, r_reg};
    assign gain_pos = !innov_den[33] && (innov_den != 34'sd0);
    assign mul_res64 = {{(64 - akf_pkg::MUL_RES_W){mul_res[akf_pkg::MUL_RES_W-1]}}, mul_res};
    assign dt_b = {17'b0, dt_reg};
    // New (t - P01 - P10 + Qa) where t is the rounded dt * P11.
    assign inner_calc = mul_res[akf_pkg::MUL_A_W-1:0]
                        - {{3{p01_reg[31]}}, p01_reg}
                        - {{3{p10_reg[31]}}, p10_reg}
                        + {4'b0000, qa_reg};

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            akf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tuser[0] ? akf_pkg::ST_OUT : akf_pkg::ST_MUL_ANGLE;
                end
            end
            akf_pkg::ST_MUL_ANGLE: if (mul_done) state_next = akf_pkg::ST_MUL_T;
            akf_pkg::ST_MUL_T:     if (mul_done) state_next = akf_pkg::ST_MUL_INNER;
            akf_pkg::ST_MUL_INNER: if (mul_done) state_next = akf_pkg::ST_MUL_QB;
            akf_pkg::ST_MUL_QB: begin
                if (mul_done) begin
                    state_next = gain_pos ? akf_pkg::ST_DIV_K0 : akf_pkg::ST_MUL_KY0;
                end
            end
            akf_pkg::ST_DIV_K0:    if (div_done) state_next = akf_pkg::ST_DIV_K1;
            akf_pkg::ST_DIV_K1:    if (div_done) state_next = akf_pkg::ST_MUL_KY0;
            akf_pkg::ST_MUL_KY0:   if (mul_done) state_next = akf_pkg::ST_MUL_KY1;
            akf_pkg::ST_MUL_KY1:   if (mul_done) state_next = akf_pkg::ST_MUL_KP10;
            akf_pkg::ST_MUL_KP10:  if (mul_done) state_next = akf_pkg::ST_MUL_KP00;
            akf_pkg::ST_MUL_KP00:  if (mul_done) state_next = akf_pkg::ST_MUL_KP11;
            akf_pkg::ST_MUL_KP11:  if (mul_done) state_next = akf_pkg::ST_MUL_KP01;
            akf_pkg::ST_MUL_KP01:  if (mul_done) state_next = akf_pkg::ST_OUT;
            akf_pkg::ST_OUT:       if (m_tready) state_next = akf_pkg::ST_IDLE;
            default:               state_next = akf_pkg::ST_IDLE;
        endcase
        launch_next = (state_next != state_reg);
    end

    // Output logic of the sequencer: handshakes, unit starts and operand selection.
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        mul_ctrl.start = 1'b0;
        mul_ctrl.dt_op = 1'b0;
        mul_a = '0;
        mul_b = '0;
        div_start = 1'b0;
        div_num = p00_reg;
        case (state_reg)
            akf_pkg::ST_IDLE: s_tready = 1'b1;
            akf_pkg::ST_OUT:  m_tvalid = 1'b1;
            akf_pkg::ST_MUL_ANGLE: begin
                mul_ctrl = '{start: launch_reg, dt_op: 1'b1};
                mul_a = {{3{rate_reg[31]}}, rate_reg};
                mul_b = dt_b;
            end
            akf_pkg::ST_MUL_T: begin
                mul_ctrl = '{start: launch_reg, dt_op: 1'b1};
                mul_a = {{3{p11_reg[31]}}, p11_reg};
                mul_b = dt_b;
            end
            akf_pkg::ST_MUL_INNER: begin
                mul_ctrl = '{start: launch_reg, dt_op: 1'b1};
                mul_a = inner_reg;
                mul_b = dt_b;
            end
            akf_pkg::ST_MUL_QB: begin
                mul_ctrl = '{start: launch_reg, dt_op: 1'b1};
                mul_a = {4'b0000, qb_reg};
                mul_b = dt_b;
            end
            akf_pkg::ST_DIV_K0: begin
                div_start = launch_reg;
                div_num = p00_reg;
            end
            akf_pkg::ST_DIV_K1: begin
                div_start = launch_reg;
                div_num = p10_reg;
            end
            akf_pkg::ST_MUL_KY0: begin
                mul_ctrl = '{start: launch_reg, dt_op: 1'b0};
                mul_a = {{3{k0_reg[31]}}, k0_reg};
                mul_b = {y_reg[31], y_reg};
            end
            akf_pkg::ST_MUL_KY1: begin
                mul_ctrl = '{start: launch_reg, dt_op: 1'b0};
                mul_a = {{3{k1_reg[31]}}, k1_reg};
                mul_b = {y_reg[31], y_reg};
            end
            akf_pkg::ST_MUL_KP10: begin
                mul_ctrl = '{start: launch_reg, dt_op: 1'b0};
                mul_a = {{3{k1_reg[31]}}, k1_reg};
                mul_b = {p00_reg[31], p00_reg};
            end
            akf_pkg::ST_MUL_KP00: begin
                mul_ctrl = '{start: launch_reg, dt_op: 1'b0};
                mul_a = {{3{k0_reg[31]}}, k0_reg};
                mul_b = {p00_reg[31], p00_reg};
            end
            akf_pkg::ST_MUL_KP11: begin
                mul_ctrl = '{start: launch_reg, dt_op: 1'b0};
                mul_a = {{3{k1_reg[31]}}, k1_reg};
                mul_b = {p01_reg[31], p01_reg};
            end
            akf_pkg::ST_MUL_KP01: begin
                mul_ctrl = '{start: launch_reg, dt_op: 1'b0};
                mul_a = {{3{k0_reg[31]}}, k0_reg};
                mul_b = {p01_reg[31], p01_reg};
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= akf_pkg::ST_IDLE;
            launch_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            launch_reg <= launch_next;
        end
    end

    // Noise registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_reg <= QA_RST;
            qb_reg <= QB_RST;
            r_reg <= R_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                akf_pkg::REG_QA: qa_reg <= pwdata[akf_pkg::REG_W-1:0];
                akf_pkg::REG_QB: qb_reg <= pwdata[akf_pkg::REG_W-1:0];
                akf_pkg::REG_R:  r_reg <= pwdata[akf_pkg::REG_W-1:0];
                default:         qa_reg <= qa_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            akf_pkg::REG_QA: prdata = {1'b0, qa_reg};
            akf_pkg::REG_QB: prdata = {1'b0, qb_reg};
            akf_pkg::REG_R:  prdata = {1'b0, r_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Filter state. Each multiplier result is folded in on the cycle its done pulse shows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0;
            bias_reg <= '0;
            rate_reg <= '0;
            p00_reg <= '0;
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= '0;
        end else if (s_accept) begin
            if (s_tuser[0]) begin
                angle_reg <= s_tdata[31:0];
            end else begin
                rate_reg <= akf_pkg::sat32(akf_pkg::ext64(s_tdata[63:32])
                                           - akf_pkg::ext64(bias_reg));
            end
        end else if (mul_done) begin
            case (state_reg)
                akf_pkg::ST_MUL_ANGLE:
                    angle_reg <= akf_pkg::sat32(akf_pkg::ext64(angle_reg) + mul_res64);
                akf_pkg::ST_MUL_T: begin
                    p01_reg <= akf_pkg::sat32(akf_pkg::ext64(p01_reg) - mul_res64);
                    p10_reg <= akf_pkg::sat32(akf_pkg::ext64(p10_reg) - mul_res64);
                end
                akf_pkg::ST_MUL_INNER:
                    p00_reg <= akf_pkg::sat32(akf_pkg::ext64(p00_reg) + mul_res64);
                akf_pkg::ST_MUL_QB:
                    p11_reg <= akf_pkg::sat32(akf_pkg::ext64(p11_reg) + mul_res64);
                akf_pkg::ST_MUL_KY0:
                    angle_reg <= akf_pkg::sat32(akf_pkg::ext64(angle_reg) + mul_res64);
                akf_pkg::ST_MUL_KY1:
                    bias_reg <= akf_pkg::sat32(akf_pkg::ext64(bias_reg) + mul_res64);
                akf_pkg::ST_MUL_KP10:
                    p10_reg <= akf_pkg::sat32(akf_pkg::ext64(p10_reg) - mul_res64);
                akf_pkg::ST_MUL_KP00:
                    p00_reg <= akf_pkg::sat32(akf_pkg::ext64(p00_reg) - mul_res64);
                akf_pkg::ST_MUL_KP11:
                    p11_reg <= akf_pkg::sat32(akf_pkg::ext64(p11_reg) - mul_res64);
                akf_pkg::ST_MUL_KP01:
                    p01_reg <= akf_pkg::sat32(akf_pkg::ext64(p01_reg) - mul_res64);
                default:
                    angle_reg <= angle_reg;
            endcase
        end
    end

    // Working values of one update.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ma_reg <= s_tdata[31:0];
            dt_reg <= s_tdata[79:64];
        end
        if (mul_done && state_reg == akf_pkg::ST_MUL_T) begin
            inner_reg <= inner_calc;
        end
        if (mul_done && state_reg == akf_pkg::ST_MUL_QB) begin
            // The innovation uses the predicted angle; gains stay zero unless divided.
            y_reg <= akf_pkg::sat32(akf_pkg::ext64(ma_reg) - akf_pkg::ext64(angle_reg));
            k0_reg <= '0;
            k1_reg <= '0;
        end
        if (div_done && state_reg == akf_pkg::ST_DIV_K0) begin
            k0_reg <= div_quot;
        end
        if (div_done && state_reg == akf_pkg::ST_DIV_K1) begin
            k1_reg <= div_quot;
        end
    end

    akf_serial_mul #(
        .COV_FRAC_BITS(COV_FRAC_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mul_ctrl),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    akf_serial_div #(
        .COV_FRAC_BITS(COV_FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (innov_den[32:0]),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign m_tdata = {rate_reg, angle_reg};

    // Input and output sides are never open together.
    `AKF_ASSERT_NOW(a_one_side, aclk, aresetn, m_tvalid, !s_tready)
    // A load word produces its result on the very next cycle.
    `AKF_ASSERT_NEXT(a_load_fast, aclk, aresetn, s_accept && s_tuser[0], m_tvalid)
    // Only one arithmetic unit finishes at a time.
    `AKF_ASSERT_NOW(a_one_unit, aclk, aresetn, mul_done, !div_done)
    // An update word always starts with the angle predict.
    `AKF_ASSERT_NEXT(a_upd_start, aclk, aresetn, s_accept && !s_tuser[0],
                     state_reg == akf_pkg::ST_MUL_ANGLE)
endmodule
